[rtl/core/kvp_pkg.sv]
`default_nettype none

package kvp_pkg;

   localparam int unsigned NUM_W   = 63;
   localparam int unsigned NUM_CMD = 7;

   typedef enum logic [2:0] {
      CMD_PING   = 3'd0,
      CMD_GET    = 3'd1,
      CMD_DEL    = 3'd2,
      CMD_EXISTS = 3'd3,
      CMD_EXPIRE = 3'd4,
      CMD_TTL    = 3'd5,
      CMD_SET    = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      ST_EMPTY = 2'd0,
      ST_OK    = 2'd1,
      ST_ERROR = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ERR_NONE    = 3'd0,
      ERR_ARGS    = 3'd1,
      ERR_EXPIRE  = 3'd2,
      ERR_SYNTAX  = 3'd3,
      ERR_UNKNOWN = 3'd4
   } err_type;

   localparam logic [NUM_CMD-1:0] CAND_ALL    = '1;
   localparam logic [NUM_CMD-1:0] CAND_EXPIRE = NUM_CMD'(1) << CMD_EXPIRE;
   localparam logic [NUM_CMD-1:0] CAND_SET    = NUM_CMD'(1) << CMD_SET;

   // keyword text, padded with zeros to a full position range
   localparam logic [7:0] KW_TEXT [0:NUM_CMD-1][0:7] = '{
      '{8'h50, 8'h49, 8'h4E, 8'h47, 8'h00, 8'h00, 8'h00, 8'h00},  // PING
      '{8'h47, 8'h45, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // GET
      '{8'h44, 8'h45, 8'h4C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // DEL
      '{8'h45, 8'h58, 8'h49, 8'h53, 8'h54, 8'h53, 8'h00, 8'h00},  // EXISTS
      '{8'h45, 8'h58, 8'h50, 8'h49, 8'h52, 8'h45, 8'h00, 8'h00},  // EXPIRE
      '{8'h54, 8'h54, 8'h4C, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},  // TTL
      '{8'h53, 8'h45, 8'h54, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}   // SET
   };
   localparam logic [2:0] KW_LEN [0:NUM_CMD-1] =
      '{3'd4, 3'd3, 3'd3, 3'd6, 3'd6, 3'd3, 3'd3};

   localparam logic [7:0] QUAL_TEXT [0:1] = '{8'h45, 8'h58};  // EX
   localparam logic [2:0] QUAL_LEN = 3'd2;

   // control from the parser to the seconds accumulator
   typedef struct packed {
      logic       clear;
      logic       enable;
      logic [7:0] ch;
   } num_ctl_type;

   typedef struct packed {
      logic [7:0]       char_out;
      logic             in_word;
      logic [2:0]       word_index;
      logic             verdict_valid;
      status_type       status;
      cmd_type          command;
      err_type          error_kind;
      logic             has_ttl;
      logic [NUM_W-1:0] expire_secs;
   } rsp_beat_type;

   function automatic logic is_space(input logic [7:0] c);
      return ((c >= 8'h09) && (c <= 8'h0D)) || (c == 8'h20);
   endfunction

   function automatic logic [7:0] fold_upper(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'h20) : c;
   endfunction

   function automatic logic [2:0] sat_inc(input logic [2:0] v);
      return (v == 3'd7) ? v : (v + 3'd1);
   endfunction

endpackage

`default_nettype wire

[rtl/core/kvp_if.sv]
`default_nettype none

interface kvp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_in;
   logic       end_mark;

   modport source (output valid, char_in, end_mark, input ready);
   modport sink   (input valid, char_in, end_mark, output ready);
endinterface

interface kvp_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  char_out;
   logic        in_word;
   logic [2:0]  word_index;
   logic        verdict_valid;
   logic [1:0]  status;
   logic [2:0]  command;
   logic [2:0]  error_kind;
   logic        has_ttl;
   logic [62:0] expire_secs;

   modport source (output valid, char_out, in_word, word_index, verdict_valid, status,
                   command, error_kind, has_ttl, expire_secs, input ready);
   modport sink   (input valid, char_out, in_word, word_index, verdict_valid, status,
                   command, error_kind, has_ttl, expire_secs, output ready);
endinterface

`default_nettype wire

[rtl/core/kvp_number_acc.sv]
`default_nettype none

// Decimal seconds accumulator: leading digits only, sticky overflow.
module kvp_number_acc
   import kvp_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire num_ctl_type      ctl,
   output logic                  num_ok,
   output logic [NUM_W-1:0]      value
);

   localparam logic [NUM_W+3:0] NUM_LIMIT = {4'b0, {NUM_W{1'b1}}};

   logic [NUM_W-1:0] value_ff, value_in;
   logic             seen_ff, seen_in;
   logic             stop_ff, stop_in;
   logic             bad_ff, bad_in;
   logic             is_digit;
   logic [3:0]       digit;
   logic [NUM_W+3:0] wide_value;
   logic [NUM_W+3:0] product;

   assign is_digit   = (ctl.ch >= 8'h30) && (ctl.ch <= 8'h39);
   assign digit      = ctl.ch[3:0];
   assign wide_value = {4'b0, value_ff};
   // value * 10 + digit, exact in 67 bits
   assign product    = (wide_value << 3) + (wide_value << 1) + {{NUM_W{1'b0}}, digit};

   always_comb begin
      value_in = value_ff;
      seen_in  = seen_ff;
      stop_in  = stop_ff;
      bad_in   = bad_ff;
      if (ctl.clear) begin
         value_in = '0;
         seen_in  = 1'b0;
         stop_in  = 1'b0;
         bad_in   = 1'b0;
      end else if (ctl.enable && !stop_ff) begin
         if (is_digit) begin
            if (!bad_ff) begin
               if (product > NUM_LIMIT) begin
                  bad_in = 1'b1;
               end else begin
                  value_in = product[NUM_W-1:0];
               end
            end
            seen_in = 1'b1;
         end else begin
            if (!seen_ff) begin
               bad_in = 1'b1;
            end
            stop_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= '0;
         seen_ff  <= 1'b0;
         stop_ff  <= 1'b0;
         bad_ff   <= 1'b0;
      end else begin
         value_ff <= value_in;
         seen_ff  <= seen_in;
         stop_ff  <= stop_in;
         bad_ff   <= bad_in;
      end
   end

   assign num_ok = seen_ff && !bad_ff && (value_ff != '0);
   assign value  = value_ff;

endmodule

`default_nettype wire

[rtl/core/kv_command_line_parser.sv]
// Streaming inline command-line checker. Send a line one byte per req beat and close it with
// a beat that has end_mark set. Every beat yields exactly one rsp beat, passing through the input
// stage and the result register: byte beats echo the byte with its token flag and token index,
// the end-of-line beat carries the verdict (status, command, error kind and any SET/EXPIRE TTL).
// Tokens split at 0x09..0x0D and 0x20; the command word is matched case-insensitively. One
// beat is taken every cycle while rsp is not stalled; the rate is set by the per-byte state
// update, whose deepest path is the x10 accumulate and overflow compare of the seconds token.
// Line state clears by itself after each end-of-line beat.
`default_nettype none

module kv_command_line_parser
   import kvp_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   kvp_req_if.sink    req_if,
   kvp_rsp_if.source  rsp_if
);

   // ---------------------------------------------------------------- input stage
   logic       s1_valid_ff;
   logic [7:0] s1_char_ff;
   logic       s1_end_ff;
   logic       advance;     // result register can take a new beat
   logic       s1_fire;     // staged beat is processed this cycle

   assign advance       = !rsp_if.valid || rsp_if.ready;
   assign s1_fire       = s1_valid_ff && advance;
   assign req_if.ready  = !s1_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_if.valid && req_if.ready) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         s1_char_ff <= req_if.char_in;
         s1_end_ff  <= req_if.end_mark;
      end
   end

   // ---------------------------------------------------------------- line state
   logic [2:0]         count_ff, count_in;       // completed tokens, saturating
   logic               inside_ff, inside_in;
   logic [2:0]         pos_ff, pos_in;           // position in current token
   logic [NUM_CMD-1:0] cand_ff, cand_in;         // command words still matching
   logic               qual_ff, qual_in;         // fourth token still matches EX

   // token close: length checks on the command word and the qualifier
   logic [2:0]         fin_count;
   logic [NUM_CMD-1:0] fin_cand;
   logic               fin_qual;

   // token byte: character checks
   logic [7:0]         upper;
   logic [2:0]         pos_eff;
   logic [NUM_CMD-1:0] byte_cand;
   logic               byte_qual;
   logic               num_take;

   // state as seen at end of line, after any open token is closed
   logic [2:0]         eol_count;
   logic [NUM_CMD-1:0] eol_cand;
   logic               eol_qual;

   num_ctl_type        num_ctl;
   logic               num_ok;
   logic [NUM_W-1:0]   num_value;

   rsp_beat_type       beat;

   assign upper   = fold_upper(s1_char_ff);
   assign pos_eff = inside_ff ? pos_ff : 3'd0;

   always_comb begin
      fin_count = sat_inc(count_ff);
      fin_cand  = cand_ff;
      fin_qual  = qual_ff;
      if (count_ff == 3'd0) begin
         for (int k = 0; k < NUM_CMD; k++) begin
            if (KW_LEN[k] != pos_ff) begin
               fin_cand[k] = 1'b0;
            end
         end
      end else if ((count_ff == 3'd3) && (pos_ff != QUAL_LEN)) begin
         fin_qual = 1'b0;
      end
   end

   always_comb begin
      byte_cand = cand_ff;
      byte_qual = qual_ff;
      if (count_ff == 3'd0) begin
         for (int k = 0; k < NUM_CMD; k++) begin
            if ((pos_eff >= KW_LEN[k]) || (KW_TEXT[k][pos_eff] != upper)) begin
               byte_cand[k] = 1'b0;
            end
         end
      end else if (count_ff == 3'd3) begin
         if ((pos_eff >= QUAL_LEN) || (QUAL_TEXT[pos_eff[0]] != upper)) begin
            byte_qual = 1'b0;
         end
      end
   end

   // seconds token: third token of EXPIRE, fifth of SET
   assign num_take = ((count_ff == 3'd2) && (cand_ff == CAND_EXPIRE)) ||
                     ((count_ff == 3'd4) && (cand_ff == CAND_SET));

   assign eol_count = inside_ff ? fin_count : count_ff;
   assign eol_cand  = inside_ff ? fin_cand  : cand_ff;
   assign eol_qual  = inside_ff ? fin_qual  : qual_ff;

   always_comb begin
      count_in  = count_ff;
      inside_in = inside_ff;
      pos_in    = pos_ff;
      cand_in   = cand_ff;
      qual_in   = qual_ff;
      num_ctl   = '{clear: 1'b0, enable: 1'b0, ch: s1_char_ff};
      if (s1_fire) begin
         if (s1_end_ff) begin
            count_in      = '0;
            inside_in     = 1'b0;
            pos_in        = '0;
            cand_in       = CAND_ALL;
            qual_in       = 1'b1;
            num_ctl.clear = 1'b1;
         end else if (is_space(s1_char_ff)) begin
            if (inside_ff) begin
               count_in  = fin_count;
               cand_in   = fin_cand;
               qual_in   = fin_qual;
               inside_in = 1'b0;
            end
         end else begin
            inside_in      = 1'b1;
            cand_in        = byte_cand;
            qual_in        = byte_qual;
            pos_in         = sat_inc(pos_eff);
            num_ctl.enable = num_take;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         inside_ff <= 1'b0;
         pos_ff    <= '0;
         cand_ff   <= CAND_ALL;
         qual_ff   <= 1'b1;
      end else begin
         count_ff  <= count_in;
         inside_ff <= inside_in;
         pos_ff    <= pos_in;
         cand_ff   <= cand_in;
         qual_ff   <= qual_in;
      end
   end

   kvp_number_acc u_number (
      .clock  (clock),
      .reset  (reset),
      .ctl    (num_ctl),
      .num_ok (num_ok),
      .value  (num_value)
   );

   // ---------------------------------------------------------------- result beat
   always_comb begin
      cmd_type cmd;
      logic    found;
      err_type err;
      logic    ttl;
      cmd   = CMD_PING;
      found = 1'b0;
      err   = ERR_NONE;
      ttl   = 1'b0;
      beat  = '0;
      if (s1_end_ff) begin
         // lowest surviving candidate wins
         for (int k = NUM_CMD - 1; k >= 0; k--) begin
            if (eol_cand[k]) begin
               cmd   = cmd_type'(k[2:0]);
               found = 1'b1;
            end
         end
         if (!found) begin
            err = ERR_UNKNOWN;
            cmd = CMD_PING;
         end else begin
            unique case (cmd)
               CMD_PING: begin
                  if (eol_count != 3'd1) err = ERR_ARGS;
               end
               CMD_EXPIRE: begin
                  priority if (eol_count != 3'd3) err = ERR_ARGS;
                  else if (!num_ok)               err = ERR_EXPIRE;
                  else                            ttl = 1'b1;
               end
               CMD_SET: begin
                  priority if (eol_count < 3'd3) err = ERR_ARGS;
                  else if (eol_count == 3'd5) begin
                     priority if (!eol_qual) err = ERR_SYNTAX;
                     else if (!num_ok)       err = ERR_EXPIRE;
                     else                    ttl = 1'b1;
                  end else if (eol_count != 3'd3) err = ERR_SYNTAX;
               end
               default: begin
                  if (eol_count != 3'd2) err = ERR_ARGS;
               end
            endcase
         end
         beat.verdict_valid = 1'b1;
         if (eol_count != 3'd0) begin
            beat.status      = (err != ERR_NONE) ? ST_ERROR : ST_OK;
            beat.command     = cmd;
            beat.error_kind  = err;
            beat.has_ttl     = ttl;
            beat.expire_secs = ttl ? num_value : '0;
         end
      end else begin
         beat.char_out = s1_char_ff;
         if (is_space(s1_char_ff)) begin
            beat.in_word    = 1'b0;
            beat.word_index = inside_ff ? fin_count : count_ff;
         end else begin
            beat.in_word    = 1'b1;
            beat.word_index = count_ff;
         end
      end
   end

   logic         rsp_valid_ff;
   rsp_beat_type rsp_beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_beat_ff <= beat;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.char_out      = rsp_beat_ff.char_out;
   assign rsp_if.in_word       = rsp_beat_ff.in_word;
   assign rsp_if.word_index    = rsp_beat_ff.word_index;
   assign rsp_if.verdict_valid = rsp_beat_ff.verdict_valid;
   assign rsp_if.status        = rsp_beat_ff.status;
   assign rsp_if.command       = rsp_beat_ff.command;
   assign rsp_if.error_kind    = rsp_beat_ff.error_kind;
   assign rsp_if.has_ttl       = rsp_beat_ff.has_ttl;
   assign rsp_if.expire_secs   = rsp_beat_ff.expire_secs;

   // ---------------------------------------------------------------- checks
   // an end-of-line beat leaves the line state at its reset values
   assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_end_ff) |=>
         (count_ff == 3'd0) && !inside_ff && (cand_ff == CAND_ALL) && qual_ff)
      else $error("line state not cleared after end of line");

   // a TTL is only reported on a clean SET or EXPIRE verdict
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.has_ttl) |->
         rsp_if.verdict_valid && (rsp_if.status == ST_OK) &&
         ((rsp_if.command == CMD_SET) || (rsp_if.command == CMD_EXPIRE)) &&
         (rsp_if.expire_secs != '0))
      else $error("TTL reported outside a clean SET/EXPIRE verdict");

   // verdict beats carry no byte, and error kind agrees with status
   assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && rsp_if.verdict_valid) |->
         !rsp_if.in_word && (rsp_if.char_out == 8'h00) &&
         ((rsp_if.status == ST_ERROR) == (rsp_if.error_kind != ERR_NONE)))
      else $error("inconsistent verdict beat");

   // a staged beat never sits while the result register is free
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("staged beat did not move to the result register");

endmodule

`default_nettype wire

[tb/sv/kv_command_line_parser_tb.sv]
`default_nettype none

module kv_command_line_parser_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kvp_pkg::*;

   // run shape
   localparam int RANDOM_ITEMS = 410;   // random part stops once this many bytes/ends are queued
   localparam int QUIET_TAIL   = 120;   // last beats of the run go without any idling
   localparam int HOLD_CYCLES  = 400;   // long rsp back-pressure stretch
   localparam int HOLD_AFTER   = 150;   // rsp beats seen before the long stretch starts
   localparam int DRAIN_CYCLES = 10;    // block answers a req beat via its input and result registers

   localparam logic [7:0]  DIGIT_0  = 8'h30;
   localparam logic [7:0]  DIGIT_9  = 8'h39;
   localparam logic [63:0] SECS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

   localparam logic [7:0] BLANKS [0:5] = '{8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20};

   // command words, indexed by command code
   string kw_name [0:6] = '{"PING", "GET", "DEL", "EXISTS", "EXPIRE", "TTL", "SET"};
   string qual_name     = "EX";

   // one req beat: a line byte or the end-of-line mark
   typedef struct packed {
      logic [7:0] ch;
      logic       eol;
   } line_byte_type;

   logic clock;
   logic reset;

   kvp_req_if req_if ();
   kvp_rsp_if rsp_if ();

   kv_command_line_parser dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   line_byte_type line_q [$];       // beats still to be offered
   rsp_beat_type  expected_q [$];   // predicted rsp beats, oldest first

   int   n_items;
   int   n_sent;
   int   n_accepted;
   int   n_checked;
   int   n_errors;
   int   send_gap;
   int   recv_gap;
   int   send_idle_pct;
   int   recv_idle_pct;
   logic hold;

   // ---------------------------------------------------------------------------------------
   // Line parser prediction: own copy of the per-line state
   // ---------------------------------------------------------------------------------------
   logic [2:0]  tok_cnt;     // finished tokens, saturating at 7
   logic        in_tok;
   logic [2:0]  tok_pos;     // position inside the current token, saturating at 7
   logic [6:0]  cand;        // bit k: command k still matches token 0
   logic        qual_ok;     // token 3 still reads EX
   logic [62:0] secs;
   logic        secs_seen;
   logic        secs_stop;
   logic        secs_bad;

   function automatic logic is_blank(input logic [7:0] b);
      case (b)
         8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20: return 1'b1;
         default:                                  return 1'b0;
      endcase
   endfunction

   // only a..z fold to upper case
   function automatic logic [7:0] upcase(input logic [7:0] b);
      if (b >= 8'h61 && b <= 8'h7A) return b & 8'hDF;
      return b;
   endfunction

   function automatic void clear_line();
      tok_cnt   = '0;
      in_tok    = 1'b0;
      tok_pos   = '0;
      cand      = '1;
      qual_ok   = 1'b1;
      secs      = '0;
      secs_seen = 1'b0;
      secs_stop = 1'b0;
      secs_bad  = 1'b0;
   endfunction

   // a token ends: length decides the last keyword matches
   function automatic void close_token();
      if (tok_cnt == 3'd0) begin
         for (int k = 0; k < 7; k++)
            if (kw_name[k].len() != tok_pos) cand[k] = 1'b0;
      end else if (tok_cnt == 3'd3) begin
         if (tok_pos != 3'd2) qual_ok = 1'b0;
      end
      if (tok_cnt != 3'd7) tok_cnt++;
      in_tok = 1'b0;
   endfunction

   function automatic rsp_beat_type line_step(input logic [7:0] c, input logic eol);
      rsp_beat_type r;
      logic [7:0]   u;
      logic [63:0]  d;
      int           first;
      err_type      err;
      logic         ttl_ok;
      logic         secs_ok;
      r = '0;
      if (!eol) begin
         r.char_out = c;
         if (is_blank(c)) begin
            if (in_tok) close_token();
            r.word_index = tok_cnt;   // index the next token would get
            return r;
         end
         if (!in_tok) begin
            in_tok  = 1'b1;
            tok_pos = '0;
         end
         r.in_word    = 1'b1;
         r.word_index = tok_cnt;
         u = upcase(c);
         if (tok_cnt == 3'd0) begin
            for (int k = 0; k < 7; k++)
               if (tok_pos >= kw_name[k].len() || kw_name[k][tok_pos] != u) cand[k] = 1'b0;
         end else if (tok_cnt == 3'd3) begin
            if (tok_pos >= 3'd2 || qual_name[tok_pos] != u) qual_ok = 1'b0;
         end
         // seconds token: token 2 of EXPIRE, token 4 of SET
         if ((tok_cnt == 3'd2 && cand == (7'd1 << CMD_EXPIRE)) ||
             (tok_cnt == 3'd4 && cand == (7'd1 << CMD_SET))) begin
            if (!secs_stop) begin
               if (c >= DIGIT_0 && c <= DIGIT_9) begin
                  d = c - DIGIT_0;
                  if (!secs_bad) begin
                     if ({1'b0, secs} > (SECS_MAX - d) / 10) secs_bad = 1'b1;
                     else secs = 63'({1'b0, secs} * 10 + d);
                  end
                  secs_seen = 1'b1;
               end else begin
                  // first non-digit ends the number; nothing read yet is an error
                  if (!secs_seen) secs_bad = 1'b1;
                  secs_stop = 1'b1;
               end
            end
         end
         if (tok_pos != 3'd7) tok_pos++;
         return r;
      end

      // end of line: verdict
      if (in_tok) close_token();
      r.verdict_valid = 1'b1;
      if (tok_cnt != 3'd0) begin
         first   = -1;
         err     = ERR_NONE;
         ttl_ok  = 1'b0;
         secs_ok = secs_seen && !secs_bad && (secs != '0);
         for (int k = 0; k < 7; k++)
            if (cand[k] && first < 0) first = k;
         if (first < 0) begin
            err       = ERR_UNKNOWN;
            r.command = CMD_PING;
         end else begin
            r.command = cmd_type'(first);
            case (r.command)
               CMD_PING: begin
                  if (tok_cnt != 3'd1) err = ERR_ARGS;
               end
               CMD_EXPIRE: begin
                  if (tok_cnt != 3'd3) err = ERR_ARGS;
                  else if (!secs_ok) err = ERR_EXPIRE;
                  else ttl_ok = 1'b1;
               end
               CMD_SET: begin
                  if (tok_cnt < 3'd3) err = ERR_ARGS;
                  else if (tok_cnt == 3'd5) begin
                     if (!qual_ok) err = ERR_SYNTAX;
                     else if (!secs_ok) err = ERR_EXPIRE;
                     else ttl_ok = 1'b1;
                  end else if (tok_cnt != 3'd3) err = ERR_SYNTAX;
               end
               default: begin
                  if (tok_cnt != 3'd2) err = ERR_ARGS;
               end
            endcase
         end
         if (err == ERR_NONE) r.status = ST_OK;
         else r.status = ST_ERROR;
         r.error_kind = err;
         if (ttl_ok) begin
            r.has_ttl     = 1'b1;
            r.expire_secs = secs;
         end
      end
      clear_line();
      return r;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Line builders
   // ---------------------------------------------------------------------------------------
   task automatic put_byte(input logic [7:0] b);
      line_byte_type it;
      it.ch  = b;
      it.eol = 1'b0;
      line_q.insert(line_q.size(), it);
   endtask

   // end mark carries a random byte that the block has to ignore
   task automatic put_eol();
      line_byte_type it;
      it.ch  = 8'($urandom);
      it.eol = 1'b1;
      line_q.insert(line_q.size(), it);
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) put_byte(s[i]);
   endtask

   // separator: usually one space, sometimes a run of mixed blanks
   task automatic put_gap();
      if ($urandom_range(0, 3) != 0) put_byte(8'h20);
      else repeat ($urandom_range(1, 3)) put_byte(BLANKS[$urandom_range(0, 5)]);
   endtask

   task automatic put_word(input string s);
      logic [7:0] b;
      for (int i = 0; i < s.len(); i++) begin
         b = s[i];
         if (b >= 8'h41 && b <= 8'h5A && $urandom_range(0, 1) != 0) b = b | 8'h20;
         put_byte(b);
      end
   endtask

   // key/value text: any non-blank byte, up to 9 long so positions saturate
   task automatic put_junk();
      logic [7:0] b;
      repeat ($urandom_range(1, 9)) begin
         do b = 8'($urandom); while (is_blank(b));
         put_byte(b);
      end
   endtask

   // near-miss of a keyword: shortened, lengthened, one letter off, or prefixed
   task automatic put_mangled(input string s);
      int at;
      at = $urandom_range(0, s.len() - 1);
      case ($urandom_range(0, 3))
         0: put_word(s.substr(0, s.len() - 2));
         1: begin
            put_word(s);
            put_byte(8'h41 + 8'($urandom_range(0, 25)));
         end
         2: begin
            s[at] = 8'h41 + 8'($urandom_range(0, 25));
            put_word(s);
         end
         default: begin
            put_byte(8'h58);
            put_word(s);
         end
      endcase
   endtask

   task automatic put_seconds();
      logic [62:0] v;
      logic [63:0] w;
      v = 63'({$urandom, $urandom} >> $urandom_range(1, 63));
      case ($urandom_range(0, 9))
         0: begin
            if ($urandom_range(0, 1) != 0) put_text("0");
            else put_text("000");
         end
         1: begin
            put_byte("-");
            put_text($sformatf("%0d", v));
         end
         2: begin
            put_byte("+");
            put_text($sformatf("%0d", v));
         end
         3: put_text("9223372036854775807");
         4: begin
            // at or above 2^63
            w = {1'b1, v};
            put_text($sformatf("%0d", w));
         end
         5: begin
            put_text($sformatf("%0d", v));
            put_junk();
         end
         6: put_junk();
         default: begin
            if ($urandom_range(0, 3) == 0) put_byte(DIGIT_0);
            put_text($sformatf("%0d", v));
         end
      endcase
   endtask

   // mostly well-formed commands with random content, some noise and blank lines
   task automatic put_random_line();
      int      pick;
      int      n_args;
      int      n_tok;
      cmd_type op;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) put_gap();
      if (pick < 84) begin
         op = cmd_type'($urandom_range(0, 6));
         case (op)
            CMD_PING:   n_args = 0;
            CMD_EXPIRE: n_args = 2;
            CMD_SET: begin
               if ($urandom_range(0, 2) == 0) n_args = 2;
               else n_args = 4;
            end
            default:    n_args = 1;
         endcase
         if ($urandom_range(0, 6) == 0) n_args = $urandom_range(0, 8);
         put_word(kw_name[op]);
         for (int a = 1; a <= n_args; a++) begin
            put_gap();
            if ((op == CMD_EXPIRE && a == 2) || (op == CMD_SET && a == 4)) put_seconds();
            else if (op == CMD_SET && a == 3) begin
               case ($urandom_range(0, 7))
                  0:       put_junk();
                  1:       put_mangled(qual_name);
                  default: put_word(qual_name);
               endcase
            end else put_junk();
         end
      end else if (pick < 94) begin
         n_tok = $urandom_range(1, 8);
         for (int t = 0; t < n_tok; t++) begin
            if (t != 0) put_gap();
            if (t == 0 && $urandom_range(0, 1) != 0) put_mangled(kw_name[$urandom_range(0, 6)]);
            else put_junk();
         end
      end
      if ($urandom_range(0, 3) == 0) put_gap();
      put_eol();
   endtask

   function automatic int pick_idle_pct();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return 5;
         2:       return 20;
         default: return 45;
      endcase
   endfunction

   // ---------------------------------------------------------------------------------------
   // req driver: offers queued beats, predicts each beat at acceptance
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin : drive_req
      line_byte_type nxt;
      logic          quiet;
      if (reset) begin
         req_if.valid    <= 1'b0;
         req_if.char_in  <= '0;
         req_if.end_mark <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_q.insert(expected_q.size(), line_step(req_if.char_in, req_if.end_mark));
            n_accepted <= n_accepted + 1;
         end
         if (!req_if.valid || req_if.ready) begin
            // keep offering during the rsp hold so the block backs up into req
            quiet = hold || (n_sent >= n_items - QUIET_TAIL);
            if (quiet) send_gap = 0;
            else if (send_gap == 0 && $urandom_range(0, 99) < send_idle_pct)
               send_gap = $urandom_range(1, 19);
            if (send_gap != 0) begin
               send_gap--;
               req_if.valid <= 1'b0;
            end else if (line_q.size() != 0) begin
               nxt = line_q.pop_front();
               req_if.valid    <= 1'b1;
               req_if.char_in  <= nxt.ch;
               req_if.end_mark <= nxt.eol;
               n_sent++;
               if (n_sent % 40 == 0) send_idle_pct = pick_idle_pct();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // rsp monitor: checks each beat against the oldest prediction, drives ready
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin : watch_rsp
      rsp_beat_type want;
      logic         bad;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_q.size() == 0) begin
               n_errors++;
               if (n_errors <= 10)
                  $display("rsp beat %0d arrived with nothing pending", n_checked);
            end else begin
               want = expected_q.pop_front();
               bad  = (rsp_if.char_out      !== want.char_out)      ||
                      (rsp_if.in_word       !== want.in_word)       ||
                      (rsp_if.word_index    !== want.word_index)    ||
                      (rsp_if.verdict_valid !== want.verdict_valid) ||
                      (rsp_if.status        !== want.status)        ||
                      (rsp_if.command       !== want.command)       ||
                      (rsp_if.error_kind    !== want.error_kind)    ||
                      (rsp_if.has_ttl       !== want.has_ttl)       ||
                      (rsp_if.expire_secs   !== want.expire_secs);
               if (bad) begin
                  n_errors++;
                  if (n_errors <= 10) begin
                     $display(
                        "rsp %0d want: ch=%h w=%b i=%0d v=%b st=%0d cmd=%0d err=%0d ttl=%b %0d",
                        n_checked, want.char_out, want.in_word, want.word_index,
                        want.verdict_valid, want.status, want.command,
                        want.error_kind, want.has_ttl, want.expire_secs);
                     $display(
                        "rsp %0d got:  ch=%h w=%b i=%0d v=%b st=%0d cmd=%0d err=%0d ttl=%b %0d",
                        n_checked, rsp_if.char_out, rsp_if.in_word, rsp_if.word_index,
                        rsp_if.verdict_valid, rsp_if.status, rsp_if.command,
                        rsp_if.error_kind, rsp_if.has_ttl, rsp_if.expire_secs);
                  end
               end
            end
            n_checked <= n_checked + 1;
            if ((n_checked + 1) % 40 == 0) recv_idle_pct = pick_idle_pct();
         end
         if (hold) begin
            rsp_if.ready <= 1'b0;
         end else if (n_checked >= n_items - QUIET_TAIL) begin
            recv_gap = 0;
            rsp_if.ready <= 1'b1;
         end else begin
            if (recv_gap == 0 && $urandom_range(0, 99) < recv_idle_pct)
               recv_gap = $urandom_range(1, 19);
            if (recv_gap != 0) begin
               recv_gap--;
               rsp_if.ready <= 1'b0;
            end else begin
               rsp_if.ready <= 1'b1;
            end
         end
      end
   end

   // long rsp stall once traffic is flowing: fills the block and stalls req
   initial begin : rsp_hold
      hold = 1'b0;
      while (n_checked < HOLD_AFTER) @(posedge clock);
      hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold <= 1'b0;
   end

   initial begin : watchdog
      #3_000_000;
      $display("kv_command_line_parser_tb: errors");
      $finish;
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus, reset and end of run
   // ---------------------------------------------------------------------------------------
   initial begin : run
      int rnd_start;
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.char_in  = '0;
      req_if.end_mark = 1'b0;
      rsp_if.ready    = 1'b0;
      n_sent          = 0;
      n_accepted      = 0;
      n_checked       = 0;
      n_errors        = 0;
      send_idle_pct   = 20;
      recv_idle_pct   = 20;
      clear_line();

      // directed lines
      put_eol();                               // empty line
      put_text("ping");                        put_eol();
      put_text("PiNg extra");                  put_eol();
      put_text("GeT k");                       put_eol();
      put_text("DEL a b");                     put_eol();
      put_text("exists a");                    put_eol();
      put_text("TTL");                         put_eol();
      put_text("EXPIRE k 30");                 put_eol();
      put_text("EXPIRE k 0");                  put_eol();   // zero seconds
      put_text("expire k -5");                 put_eol();   // leading minus
      put_text("EXPIRE k +5");                 put_eol();
      put_text("EXPIRE k 12abc");              put_eol();   // trailing text ignored
      put_text("EXPIRE k 9223372036854775807"); put_eol();  // largest value
      put_text("EXPIRE k 9223372036854775808"); put_eol();  // overflow
      put_text("SET k v");                     put_eol();
      put_text("set k v eX 45");               put_eol();
      put_text("SET k v EXX 5");               put_eol();   // bad qualifier
      put_text("SET k v EX");                  put_eol();   // four tokens
      put_text("SET k");                       put_eol();
      put_text("SET k v EX 1 2");              put_eol();
      put_text("EXPIREXX k 5");                put_eol();   // long first token
      put_text("GET a b c d e f g h");         put_eol();   // token index saturates
      // every blank kind around a command
      put_byte(8'h20); put_byte(8'h09); put_text("PING");
      put_byte(8'h0A); put_byte(8'h0B); put_byte(8'h0C); put_byte(8'h0D);
      put_eol();
      // byte extremes inside tokens, NUL starting the command word
      put_byte(8'h00); put_text("ET "); put_byte(8'hFF); put_byte(8'h80); put_byte(8'h7F);
      put_eol();
      put_text("GET "); put_byte(8'h00); put_byte(8'hFF);
      put_eol();

      rnd_start = line_q.size();
      while (line_q.size() - rnd_start < RANDOM_ITEMS) put_random_line();
      n_items = line_q.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (n_accepted != n_items) @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (n_errors == 0 && expected_q.size() == 0)
         $display("kv_command_line_parser_tb: clean");
      else
         $display("kv_command_line_parser_tb: errors");
      $finish;
   end

endmodule

`default_nettype wire
